// ----- rtl/core/wmcp_pkg.sv -----
// ----------------------------------------------------------------------------
// wmcp_pkg
// Shared widths, constants and types for the windowed min-cost path block.
// ----------------------------------------------------------------------------
package wmcp_pkg;

   localparam int HEIGHT_W = 14;
   localparam int COST_W   = 32;
   localparam int WIN_W    = 8;

   localparam logic [COST_W-1:0] COST_MAX = '1;

   // Query token that walks down the cell chain, one cell per cycle.
   typedef struct packed {
      logic                valid;
      logic [HEIGHT_W-1:0] height;
      logic [COST_W-1:0]   best;
   } wmcp_token_type;

endpackage

// ----- rtl/core/wmcp_cell.sv -----
// ----------------------------------------------------------------------------
// wmcp_cell
// One window slot: holds a stone's height and cost, shifts on push, and folds
// its candidate cost into the passing query token.
// ----------------------------------------------------------------------------
module wmcp_cell #(
   parameter int CntW = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push_en,
   input  logic [wmcp_pkg::HEIGHT_W-1:0] shift_height,
   input  logic [wmcp_pkg::COST_W-1:0]   shift_cost,
   output logic [wmcp_pkg::HEIGHT_W-1:0] stone_height,
   output logic [wmcp_pkg::COST_W-1:0]   stone_cost,
   input  wmcp_pkg::wmcp_token_type      tok_in,
   input  logic [CntW-1:0]               left_in,
   output wmcp_pkg::wmcp_token_type      tok_out,
   output logic [CntW-1:0]               left_out
);
   import wmcp_pkg::*;

   logic [HEIGHT_W-1:0] height_ff;
   logic [COST_W-1:0]   cost_ff;
   wmcp_token_type      tok_ff;
   wmcp_token_type      tok_in_next;
   logic [CntW-1:0]     left_ff;
   logic [CntW-1:0]     left_in_next;
   logic [HEIGHT_W-1:0] diff;
   logic [COST_W:0]     sum;
   logic [COST_W-1:0]   cand;
   logic                take;

   always_comb begin
      if (height_ff >= tok_in.height) begin
         diff = height_ff - tok_in.height;
      end else begin
         diff = tok_in.height - height_ff;
      end
      sum  = {1'b0, cost_ff} + (COST_W+1)'(diff);
      cand = sum[COST_W] ? COST_MAX : sum[COST_W-1:0];
      // only slots inside the span take part
      take = tok_in.valid && (left_in != '0) && (cand < tok_in.best);

      tok_in_next.valid  = tok_in.valid;
      tok_in_next.height = tok_in.height;
      tok_in_next.best   = take ? cand : tok_in.best;
      left_in_next       = (left_in != '0) ? left_in - CntW'(1) : left_in;
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         height_ff <= shift_height;
         cost_ff   <= shift_cost;
      end
   end

   // token payload needs no reset; only its valid bit does
   always_ff @(posedge clock) begin
      tok_ff.height <= tok_in_next.height;
      tok_ff.best   <= tok_in_next.best;
      left_ff       <= left_in_next;
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff.valid <= tok_in_next.valid;
      end
   end

   assign stone_height = height_ff;
   assign stone_cost   = cost_ff;
   assign tok_out      = tok_ff;
   assign left_out     = left_ff;

endmodule

// ----- rtl/core/windowed_min_cost_path_dp_top.sv -----
// ----------------------------------------------------------------------------
// windowed_min_cost_path_dp_top
// Flow: a stone that extends a path walks its query through the whole cell
//   chain (ST_RUN) before its cost is pushed and emitted (ST_DONE); a stone
//   that starts a path goes straight to ST_DONE. One stone at a time: the next
//   stone can enter only after ST_DONE; the query walks one cell per cycle.
// Reset: synchronous; window size returns to 1 and the path is emptied.
// ----------------------------------------------------------------------------
module windowed_min_cost_path_dp_top #(
   parameter int MAX_WINDOW = 128
) (
   input  logic                          clock,
   input  logic                          reset,
   // input stones
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [wmcp_pkg::HEIGHT_W-1:0] req_height,
   input  logic                          req_first,
   // cost results
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [wmcp_pkg::COST_W-1:0]   rsp_cost,
   // window size register
   input  logic                          csr_wr_en,
   input  logic [wmcp_pkg::WIN_W-1:0]    csr_wr_data
);
   import wmcp_pkg::*;

   // count of valid slots, 0..MAX_WINDOW
   localparam int CntW = $clog2(MAX_WINDOW + 1);
   localparam int CmpW = (CntW > WIN_W) ? CntW : WIN_W;

   localparam logic [1:0] ST_IDLE = 2'd0;  // waiting for a stone
   localparam logic [1:0] ST_RUN  = 2'd1;  // query walking the chain
   localparam logic [1:0] ST_DONE = 2'd2;  // cost known, push and emit

   logic [1:0]          state_ff, state_in;
   logic [WIN_W-1:0]    window_ff;
   logic [CntW-1:0]     count_ff, count_in;
   logic [HEIGHT_W-1:0] hold_height_ff, hold_height_in;
   logic                hold_restart_ff, hold_restart_in;
   logic [COST_W-1:0]   best_ff, best_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [COST_W-1:0]   rsp_cost_ff, rsp_cost_in;

   logic                accept;
   logic                restart;
   logic                out_free;
   logic                push_en;
   logic [CntW-1:0]     k_eff;
   logic [CntW-1:0]     span;

   // cell chain wiring; slot 0 holds the newest stone
   wmcp_token_type      tok_chain [MAX_WINDOW+1];
   logic [CntW-1:0]     left_chain [MAX_WINDOW+1];
   logic [HEIGHT_W-1:0] sh_in  [MAX_WINDOW];
   logic [COST_W-1:0]   sc_in  [MAX_WINDOW];
   logic [HEIGHT_W-1:0] sh_out [MAX_WINDOW];
   logic [COST_W-1:0]   sc_out [MAX_WINDOW];

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   // no live path means the stone starts one
   assign restart   = req_first || (count_ff == '0);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign push_en   = (state_ff == ST_DONE) && out_free;

   // effective K: zero acts as one, clipped to the chain length
   always_comb begin
      if (window_ff == '0) begin
         k_eff = CntW'(1);
      end else if (CmpW'(window_ff) > CmpW'(MAX_WINDOW)) begin
         k_eff = CntW'(MAX_WINDOW);
      end else begin
         k_eff = CntW'(window_ff);
      end
      span = (count_ff < k_eff) ? count_ff : k_eff;
   end

   // query launch into slot 0
   assign tok_chain[0].valid  = accept && !restart;
   assign tok_chain[0].height = req_height;
   assign tok_chain[0].best   = COST_MAX;
   assign left_chain[0]       = span;

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      hold_height_in  = hold_height_ff;
      hold_restart_in = hold_restart_ff;
      best_in         = best_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_cost_in     = rsp_cost_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               hold_height_in  = req_height;
               hold_restart_in = restart;
               if (restart) begin
                  best_in  = '0;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            // token leaves the last cell with the window minimum
            if (tok_chain[MAX_WINDOW].valid) begin
               best_in  = tok_chain[MAX_WINDOW].best;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_cost_in  = best_ff;
               if (hold_restart_ff) begin
                  count_in = CntW'(1);
               end else if (count_ff != CntW'(MAX_WINDOW)) begin
                  count_in = count_ff + CntW'(1);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         window_ff    <= WIN_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            window_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      hold_height_ff  <= hold_height_in;
      hold_restart_ff <= hold_restart_in;
      best_ff         <= best_in;
      rsp_cost_ff     <= rsp_cost_in;
   end

   // chain of slots; a push shifts every slot one place older
   for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
      if (g == 0) begin : g_head
         assign sh_in[g] = hold_height_ff;
         assign sc_in[g] = best_ff;
      end else begin : g_body
         assign sh_in[g] = sh_out[g-1];
         assign sc_in[g] = sc_out[g-1];
      end

      wmcp_cell #(
         .CntW (CntW)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .push_en      (push_en),
         .shift_height (sh_in[g]),
         .shift_cost   (sc_in[g]),
         .stone_height (sh_out[g]),
         .stone_cost   (sc_out[g]),
         .tok_in       (tok_chain[g]),
         .left_in      (left_chain[g]),
         .tok_out      (tok_chain[g+1]),
         .left_out     (left_chain[g+1])
      );
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_cost  = rsp_cost_ff;

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for windowed_min_cost_path_dp_top. Streams of stone
// heights go in, grouped into paths of mixed length and height profile, under
// a series of window sizes. A scoreboard class keeps its own copy of the
// window and predicts the cost of every stone. Both sides idle at random.
// ----------------------------------------------------------------------------
module testbench;
   import wmcp_pkg::*;

   localparam int MAX_WIN        = 128;
   localparam int IDLE_MAX       = 17;
   // a stone that extends a path walks the whole cell chain
   localparam int LATENCY        = MAX_WIN + 2;
   // worst quiet stretch of a good run: sender gap + chain walk + receiver stall
   localparam int WATCHDOG_LIMIT = 10 * (LATENCY + 2 * IDLE_MAX + 4);
   localparam int PHASE_STONES   = 195;
   localparam int MAX_PRINTED    = 40;

   typedef enum {COST_OK, COST_WRONG, COST_UNEXPECTED} cost_check_type;

   // -------------------------------------------------------------------------
   // Cost predictor and store of expected costs
   // -------------------------------------------------------------------------
   class stone_cost_board;
      logic [HEIGHT_W-1:0] height_hist[MAX_WIN];   // newest stone at slot 0
      logic [COST_W-1:0]   cost_hist[MAX_WIN];
      int unsigned         path_depth;             // live slots, saturates
      logic [WIN_W-1:0]    window_reg;
      logic [COST_W-1:0]   cost_q[$];

      function new();
         foreach (height_hist[i]) begin
            height_hist[i] = '0;
            cost_hist[i]   = '0;
         end
         path_depth = 0;
         window_reg = WIN_W'(1);
      endfunction

      function void set_window(input logic [WIN_W-1:0] value);
         window_reg = value;
      endfunction

      // Called on every accepted stone; queues the cost it must produce.
      function void note_stone(input logic [HEIGHT_W-1:0] hgt, input logic first);
         int unsigned       span;
         logic [COST_W-1:0] best;
         logic [COST_W-1:0] diff;
         logic [COST_W:0]   sum;
         // zero acts as one, anything past the chain length acts as full chain
         span = (window_reg == 0) ? 1 : window_reg;
         if (span > MAX_WIN)
            span = MAX_WIN;
         if (first || path_depth == 0) begin
            path_depth = 0;
            best       = '0;
         end else begin
            if (path_depth < span)
               span = path_depth;
            best = COST_MAX;
            for (int i = 0; i < span; i++) begin
               diff = COST_W'((height_hist[i] > hgt) ? height_hist[i] - hgt
                                                     : hgt - height_hist[i]);
               sum  = {1'b0, cost_hist[i]} + (COST_W+1)'(diff);
               if (sum[COST_W])
                  sum = {1'b0, COST_MAX};
               if (sum[COST_W-1:0] < best)
                  best = sum[COST_W-1:0];
            end
         end
         for (int i = MAX_WIN - 1; i > 0; i--) begin
            height_hist[i] = height_hist[i-1];
            cost_hist[i]   = cost_hist[i-1];
         end
         height_hist[0] = hgt;
         cost_hist[0]   = best;
         if (path_depth < MAX_WIN)
            path_depth++;
         cost_q.push_back(best);
      endfunction

      function int pending();
         return cost_q.size();
      endfunction

      function cost_check_type check_cost(input logic [COST_W-1:0] got,
                                          output logic [COST_W-1:0] want);
         want = 'x;
         if (cost_q.size() == 0)
            return COST_UNEXPECTED;
         want = cost_q.pop_front();
         return (got === want) ? COST_OK : COST_WRONG;
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, DUT hookup
   // -------------------------------------------------------------------------
   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [HEIGHT_W-1:0] req_height;
   logic                req_first;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [COST_W-1:0]   rsp_cost;
   logic                csr_wr_en;
   logic [WIN_W-1:0]    csr_wr_data;

   stone_cost_board board = new();
   int  errors       = 0;
   int  quiet_cycles = 0;
   bit  calm;            // set: neither side idles (a burst stretch)

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   windowed_min_cost_path_dp_top #(
      .MAX_WINDOW (MAX_WIN)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_height  (req_height),
      .req_first   (req_first),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_cost    (rsp_cost),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // One line per mismatch, capped so a broken block cannot flood the log.
   task automatic report(input string msg);
      if (errors < MAX_PRINTED)
         $display("ERROR @%0t: %s", $time, msg);
      errors++;
   endtask

   // -------------------------------------------------------------------------
   // Input side. All tasks are entered and left on a rising-edge step.
   // -------------------------------------------------------------------------

   // Offer one stone after a random gap; valid stays high when the next gap
   // is zero so back-to-back transfers are possible.
   task automatic send_stone(input logic [HEIGHT_W-1:0] hgt, input logic first);
      int gap;
      gap = calm ? 0 : $urandom_range(0, IDLE_MAX);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_height <= hgt;
      req_first  <= first;
      // req_stall read right after the edge is the value the edge saw
      do @(posedge clock); while (req_stall);
      board.note_stone(hgt, first);
   endtask

   // Drop valid and wait until every queued cost has come back.
   task automatic drain_costs();
      req_valid <= 1'b0;
      while (board.pending() != 0)
         @(posedge clock);
   endtask

   // Window write, only ever issued with the block drained.
   task automatic write_window(input logic [WIN_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      board.set_window(value);
   endtask

   // Random paths: mostly long ones that fill and overrun the window, some
   // short ones, and now and then a path that runs on without a first flag.
   task automatic run_paths(input int count);
      int                  left;
      int                  style;
      logic [HEIGHT_W-1:0] base;
      logic [HEIGHT_W-1:0] hgt;
      logic                start;
      left  = 0;
      style = 0;
      base  = '0;
      for (int i = 0; i < count; i++) begin
         start = 1'b0;
         if (left == 0) begin
            case ($urandom_range(0, 9))
               0, 1:    left = $urandom_range(1, 4);
               2, 3, 4: left = $urandom_range(5, 60);
               default: left = $urandom_range(MAX_WIN + 1, 2 * MAX_WIN + 40);
            endcase
            style = $urandom_range(0, 3);
            base  = HEIGHT_W'($urandom);
            calm  = ($urandom_range(0, 3) == 0);
            start = ($urandom_range(0, 7) != 0);
         end
         case (style)
            0: hgt = HEIGHT_W'($urandom);                                // full range
            1: hgt = HEIGHT_W'(base + $urandom_range(0, 63) - 32);       // close heights
            2: hgt = $urandom_range(0, 1) ? '1 : '0;                     // extremes only
            default: begin                                               // climbing ramp
               base = HEIGHT_W'(base + $urandom_range(0, 300));
               hgt  = base;
            end
         endcase
         send_stone(hgt, start);
         left--;
      end
   endtask

   // -------------------------------------------------------------------------
   // Result side: per result draw a stall length, then take the transfer.
   // -------------------------------------------------------------------------
   initial begin : rsp_receiver
      int hold;
      rsp_stall <= 1'b0;
      @(posedge clock);
      forever begin
         hold = calm ? 0 : $urandom_range(0, IDLE_MAX);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid === 1'b1 && !rsp_stall));
      end
   end

   // Check every cost transfer against the oldest expectation.
   always @(posedge clock) begin : cost_monitor
      logic [COST_W-1:0] want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         case (board.check_cost(rsp_cost, want))
            COST_WRONG:
               report($sformatf("cost mismatch: got %0d, expected %0d", rsp_cost, want));
            COST_UNEXPECTED:
               report($sformatf("cost %0d with nothing pending", rsp_cost));
            default: ;
         endcase
      end
   end

   // Watchdog: too long without any transfer means the block is hung.
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", quiet_cycles);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Test sequence
   // -------------------------------------------------------------------------
   initial begin : stimulus
      logic [WIN_W-1:0] win_plan[10];
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_height  <= '0;
      req_first   <= 1'b0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;

      // zero, full chain, beyond the chain, the small ones, around the edge
      win_plan = '{8'd0, 8'(MAX_WIN), 8'd255, 8'd1, 8'd2, 8'(MAX_WIN - 1),
                   8'(MAX_WIN + 1), 8'd3, 8'd0, 8'd0};
      win_plan[8] = WIN_W'($urandom_range(4, MAX_WIN - 2));
      win_plan[9] = WIN_W'($urandom_range(MAX_WIN + 2, 254));

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed, window at its reset value of 1. The first stone comes with
      // no first flag and an empty path, so it must still cost nothing.
      send_stone(14'd5, 1'b0);
      send_stone('1, 1'b0);
      send_stone('0, 1'b0);
      send_stone('1, 1'b0);
      send_stone('0, 1'b1);
      send_stone('0, 1'b0);
      send_stone('1, 1'b1);
      send_stone('0, 1'b0);

      for (int p = 0; p < 10; p++) begin
         drain_costs();
         write_window(win_plan[p]);
         // a dip that only a window of two or more can jump over
         if (p < 2) begin
            send_stone(14'd100, 1'b1);
            send_stone(14'd50, 1'b0);
            send_stone(14'd100, 1'b0);
         end
         run_paths(PHASE_STONES);
      end

      drain_costs();
      repeat (LATENCY + 4) @(posedge clock);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/wmcp_pkg.sv
rtl/core/wmcp_cell.sv
rtl/core/windowed_min_cost_path_dp_top.sv
sim/testbench.sv
